// ===== rtl/swsal_pkg.sv =====
// Shared types and sizes for the shortest window sum block.
// No dependencies; used by swsal_cell and shortest_window_sum_at_least.
package swsal_pkg;

  localparam int MAX_LEN      = 1024;
  localparam int SAMPLE_WIDTH = 32;
  localparam int DEPTH        = MAX_LEN + 1;
  localparam int LEN_W        = $clog2(MAX_LEN + 1);
  localparam int PREFIX_W     = SAMPLE_WIDTH + LEN_W;
  localparam int THRESH_W     = 32;
  localparam logic signed [THRESH_W-1:0] THRESH_RESET = THRESH_W'(1);

  typedef logic [LEN_W-1:0]           len_t;
  typedef logic signed [PREFIX_W-1:0] prefix_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic    shift;   // drop the front entry, everyone moves one cell left
    logic    update;  // drop back entries not below prefix, push new pair
    logic    clear;   // return to the origin-only deque
    prefix_t prefix;  // new running prefix
    len_t    pos;     // new position
  } ctl_t;

endpackage

// ===== rtl/swsal_cell.sv =====
// One deque entry of the shortest window sum block.
// Depends on swsal_pkg for ctl_t, prefix_t and len_t.
module swsal_cell (
  input  logic               clk,
  input  logic               is_origin,
  input  swsal_pkg::ctl_t    ctl,
  input  logic               right_valid,
  input  swsal_pkg::len_t    right_pos,
  input  swsal_pkg::prefix_t right_prefix,
  input  logic               left_keep,
  output logic               valid,
  output swsal_pkg::len_t    pos,
  output swsal_pkg::prefix_t prefix,
  output logic               keep
);

  // Entry survives the back pops only if its prefix is below the new one.
  assign keep = valid && (prefix < ctl.prefix);

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      valid <= is_origin;
      pos <= '0;
      prefix <= '0;
    end else if (ctl.shift) begin
      valid <= right_valid;
      pos <= right_pos;
      prefix <= right_prefix;
    end else if (ctl.update) begin
      if (!keep) begin
        // first free cell after the kept run takes the new pair
        valid <= left_keep;
        pos <= ctl.pos;
        prefix <= ctl.prefix;
      end
    end
  end

endmodule

// ===== rtl/shortest_window_sum_at_least.sv =====
// Top level of the shortest window sum block: sequencer, result register, cell row.
// Depends on swsal_pkg and swsal_cell.
//
// Usage: samples of one array enter on the input channel (in_valid, in_stall,
// sample, last_sample), one word per sample; last_sample closes the array.
// Each sample yields one result word on the output channel (out_valid,
// out_stall, best_length, found, overflow, end_of_array). The threshold is
// written through threshold_we/threshold_data only while the block is idle;
// the user is bound to this, the block itself does not enforce it. The deque
// lives in a row of DEPTH cells, front at cell zero. An item is accepted in
// the idle state, then one front entry is popped per cycle while the front
// window sum reaches the threshold, until a test finds nothing more to pop;
// the final step does the back pops and push and loads the result register.
// Each entry is popped at most once. A sample past MAX_LEN skips the front
// pops, the back pops and the push. out_valid rises as the result loads.
// Reset clears the cell row to the origin entry, the threshold to 1 and
// empties the result register. While the receiver stalls, the result holds
// and the next item waits in the final step until the register frees.
// After a word with last_sample, all array state returns to its initial value.
module shortest_window_sum_at_least (
  input  logic        clk,
  input  logic        rst,
  input  logic        threshold_we,
  input  logic [31:0] threshold_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [swsal_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic        last_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [swsal_pkg::LEN_W-1:0] best_length,
  output logic        found,
  output logic        overflow,
  output logic        end_of_array
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FRONT = 2'd1;
  localparam logic [1:0] S_OUT   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic signed [swsal_pkg::THRESH_W-1:0] threshold;
  swsal_pkg::prefix_t running;
  swsal_pkg::len_t    cnt;
  swsal_pkg::len_t    shortest;
  logic               ovf;
  logic               cur_last;
  logic               cur_skip;

  swsal_pkg::ctl_t ctl;
  logic               cv [swsal_pkg::DEPTH+1];
  swsal_pkg::len_t    cp [swsal_pkg::DEPTH+1];
  swsal_pkg::prefix_t cx [swsal_pkg::DEPTH+1];
  logic               ck [swsal_pkg::DEPTH];

  logic in_acc, out_free, front_pop, finish;
  logic signed [swsal_pkg::PREFIX_W+1:0] diff;
  swsal_pkg::len_t len;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // exact window sum test on the front entry
  assign diff = (swsal_pkg::PREFIX_W+2)'(running) - (swsal_pkg::PREFIX_W+2)'(cx[0]);
  assign front_pop = (state == S_FRONT) && cv[0] &&
                     (diff >= (swsal_pkg::PREFIX_W+2)'(threshold));
  assign len = cnt - cp[0];
  assign finish = (state == S_OUT) && out_free;

  always_comb begin
    ctl.shift  = front_pop;
    ctl.update = finish && !cur_skip;
    ctl.clear  = rst || (finish && cur_last);
    ctl.prefix = running;
    ctl.pos    = cnt;
  end

  assign cv[swsal_pkg::DEPTH] = 1'b0;
  assign cp[swsal_pkg::DEPTH] = '0;
  assign cx[swsal_pkg::DEPTH] = '0;

  for (genvar i = 0; i < swsal_pkg::DEPTH; i++) begin : g_cell
    swsal_cell u_cell (
      .clk         (clk),
      .is_origin   (i == 0),
      .ctl         (ctl),
      .right_valid (cv[i+1]),
      .right_pos   (cp[i+1]),
      .right_prefix(cx[i+1]),
      .left_keep   ((i == 0) ? 1'b1 : ck[(i == 0) ? 0 : i-1]),
      .valid       (cv[i]),
      .pos         (cp[i]),
      .prefix      (cx[i]),
      .keep        (ck[i])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = (cnt >= swsal_pkg::LEN_W'(swsal_pkg::MAX_LEN)) ? S_OUT : S_FRONT;
        end
      end
      S_FRONT: begin
        if (!front_pop) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      threshold <= swsal_pkg::THRESH_RESET;
      running <= '0;
      cnt <= '0;
      shortest <= '0;
      ovf <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (threshold_we) begin
        threshold <= threshold_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_acc) begin
        cur_last <= last_sample;
        if (cnt >= swsal_pkg::LEN_W'(swsal_pkg::MAX_LEN)) begin
          ovf <= 1'b1;
          cur_skip <= 1'b1;
        end else begin
          cur_skip <= 1'b0;
          running <= running + swsal_pkg::PREFIX_W'(sample);
          cnt <= cnt + 1'b1;
        end
      end
      if (front_pop && (shortest == '0 || len < shortest)) begin
        shortest <= len;
      end
      if (finish) begin
        out_valid <= 1'b1;
        best_length <= shortest;
        found <= (shortest != '0);
        overflow <= ovf;
        end_of_array <= cur_last;
        if (cur_last) begin
          running <= '0;
          cnt <= '0;
          shortest <= '0;
          ovf <= 1'b0;
        end
      end
    end
  end

  a_origin_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> cv[0]) else $error("deque empty while idle");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state != S_IDLE) else $error("accepted word not processed");
  a_found_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> found == (best_length != '0)) else $error("found flag mismatch");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= swsal_pkg::LEN_W'(swsal_pkg::MAX_LEN)) else $error("position count overrun");

endmodule
